// File: rtl/core/mvcm_pkg.sv
// Package with the constants, codes, types and constant tables of the value curve mapper.
`timescale 1ns / 1ps

package mvcm_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int XW          = FRAC_BITS + 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic signed [XW-1:0] ONE_S     = XW'(1 << FRAC_BITS);
    localparam logic signed [XW-1:0] NEG_ONE_S = -ONE_S;
    localparam logic [31:0]          MAG_ONE   = 32'h8000_0000;

    localparam int BEND_SHIFT = FRAC_BITS - 13;
    localparam logic [13:0] BEND_CENTER = 14'd8192;
    localparam logic [6:0]  CTRL_MAX    = 7'd127;

    localparam logic [FRAC_BITS:0] SQ_ZERO_LIM = (FRAC_BITS + 1)'(7);

    localparam int LOG_DEPTH  = 256;
    localparam int LOG_IDX_W  = $clog2(LOG_DEPTH);
    localparam int LOG_FRAC_W = FRAC_BITS - LOG_IDX_W;
    localparam logic [63:0] LOG2_TEN_Q32 = 64'd14267572527;

    localparam logic [13:0]  ACC_DEAD    = 14'd200;
    localparam int           ACC_SQ_W    = 26;
    localparam logic [35:0]  ACC_BIAS    = 36'd499000;
    localparam logic [31:0]  ACC_HI_BIAS = 32'd31187;
    localparam logic [19:0]  ACC_DIV     = 20'd998001;
    localparam logic [28:0]  ACC_RECIP   = 29'((64'd1 << 48) / 64'd998001);

    localparam logic signed [31:0] RANGE_HIGH_RESET = 32'sd65536;
    localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
    localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RANGE_LOW    = 3'd0,
        REG_RANGE_HIGH   = 3'd1,
        REG_MESSAGE_KIND = 3'd2,
        REG_CURVE_KIND   = 3'd3,
        REG_ACCEL_ENABLE = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CURVE_LINEAR = 2'd0,
        CURVE_LOG    = 2'd1,
        CURVE_SQUARE = 2'd2
    } curve_t;

    typedef enum logic [2:0] {
        OP_LINEAR,
        OP_LOG,
        OP_SQUARE,
        OP_ZERO,
        OP_ACCEL
    } op_t;

    typedef logic [FRAC_BITS:0] ctrl_tab_t [128];
    typedef logic [31:0] log_tab_t [LOG_DEPTH];

    function automatic ctrl_tab_t build_ctrl_tab();
        ctrl_tab_t t;
        for (int i = 0; i < 128; i++) begin
            t[i] = (FRAC_BITS + 1)'(((64'(i) << FRAC_BITS) + 64'd63) / 64'd127);
        end
        return t;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = val;
        r = '0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (b > n) begin
                b = b >> 2;
            end
        end
        for (int k = 0; k < 32; k++) begin
            if (b != '0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Entry j holds 10^((j + off) / LOG_DEPTH - 1) in Q1.31, built as 2^-e from square roots.
    function automatic log_tab_t build_log_tab(input int off);
        log_tab_t t;
        logic [63:0] root [32];
        logic [63:0] e;
        logic [63:0] v;
        logic [63:0] n;
        root[0] = '0;
        root[1] = isqrt64(64'd1 << 61);
        for (int k = 2; k < 32; k++) begin
            root[k] = isqrt64(root[k-1] << 31);
        end
        for (int j = 0; j < LOG_DEPTH; j++) begin
            e = (64'(LOG_DEPTH - j - off) * LOG2_TEN_Q32) / LOG_DEPTH;
            n = e >> 32;
            v = 64'd1 << 31;
            for (int k = 1; k < 32; k++) begin
                if (e[32-k]) begin
                    v = (v * root[k] + (64'd1 << 30)) >> 31;
                end
            end
            if (n >= 64'd32) begin
                v = '0;
            end else if (n > 64'd0) begin
                v = (v + (64'd1 << (n - 64'd1))) >> n;
            end
            t[j] = v[31:0];
        end
        return t;
    endfunction

    localparam ctrl_tab_t CTRL_TAB = build_ctrl_tab();
    localparam log_tab_t  LOG_LO   = build_log_tab(0);
    localparam log_tab_t  LOG_HI   = build_log_tab(1);

endpackage

// File: rtl/core/midi_value_curve_mapper.sv
// Top level of the value curve mapper: configuration registers and the mapping pipeline.
`timescale 1ns / 1ps

// The block maps one raw controller value to a signed Q16.16 result within a
// configured range. Input words arrive on value_valid/value_ready with the
// 14-bit midi_value; results leave on mapped_valid/mapped_ready as the 32-bit
// mapped_value, one result word per input word, in order.
// Configuration is a write-only port: cfg_write with cfg_index and cfg_data
// updates one register in the cycle it is high. Registers must be changed only
// while no word is in flight; the block itself does not enforce this.
// The datapath is an eight-stage pipeline, stages 1 to 8: mapped_valid rises
// once the word accepted into stage 1 reaches stage 8, and one word can be
// accepted every cycle while the receiver does not stall the output.
// The longest stages hold the widest multipliers: the reciprocal divide of the
// acceleration curve and the final product with the range span.
// When the receiver stalls, words stay in their stages and empty stages still
// fill, so the input keeps accepting until every stage holds a word.
// Reset clears the pipeline and sets the range to 0..1, controller values,
// linear curve and no acceleration.
module midi_value_curve_mapper
    import mvcm_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          value_valid,
    output logic                          value_ready,
    input  logic [13:0]                   midi_value,
    output logic                          mapped_valid,
    input  logic                          mapped_ready,
    output logic signed [31:0]            mapped_value
);

    logic signed [31:0] range_low_reg;
    logic signed [31:0] range_high_reg;
    logic               message_kind_reg;
    logic [1:0]         curve_kind_reg;
    logic               accel_enable_reg;
    logic signed [31:0] range_bottom_reg;
    logic signed [31:0] range_bottom_next;
    logic signed [31:0] range_top_next;
    logic [32:0]        range_span_reg;
    logic [32:0]        range_span_next;

    logic [8:1] valid_reg;
    logic [8:1] load;

    logic signed [14:0]    bend_d;
    logic [13:0]           bend_mag;
    logic                  accel_on;
    op_t                   s1_op_reg, s1_op_next;
    logic                  s1_neg_reg;
    logic [12:0]           s1_dist_reg, s1_dist_next;
    logic signed [XW-1:0]  s1_x_reg, s1_x_next;

    logic [FRAC_BITS:0]     s2_ax;
    logic [FRAC_BITS:0]     s2_mul_a;
    op_t                    s2_op_reg, s2_op_next;
    logic                   s2_neg_reg, s2_neg_next;
    logic [33:0]            s2_sq_reg, s2_sq_next;
    logic [FRAC_BITS:0]     s2_ax_reg;
    logic [31:0]            s2_lo_reg, s2_hi_reg;
    logic [LOG_FRAC_W-1:0]  s2_f_reg;
    logic                   s2_ge_one_reg, s2_le_neg_reg, s2_nonpos_reg;
    logic [LOG_IDX_W-1:0]   s2_idx;

    logic [31:0]  s3_mhi;
    logic [60:0]  s3_qprod;
    logic [31:0]  s3_diff;
    logic [32:0]  s3_sq_sum;
    logic [31:0]  s3_mag_sq;
    op_t          s3_op_reg;
    logic         s3_neg_reg;
    logic [16:0]  s3_q_est_reg, s3_q_est_next;
    logic [35:0]  s3_m_reg, s3_m_next;
    logic [39:0]  s3_t_reg, s3_t_next;
    logic [31:0]  s3_lo_reg;
    logic [31:0]  s3_mag_reg, s3_mag_next;
    logic         s3_nonpos_reg, s3_ge_one_reg;

    logic [32:0]  s4_y_log;
    op_t          s4_op_reg;
    logic         s4_neg_reg;
    logic [16:0]  s4_q_est_reg;
    logic [35:0]  s4_m_reg;
    logic [36:0]  s4_qd_reg, s4_qd_next;
    logic [31:0]  s4_mag_reg, s4_mag_next;

    logic         s5_bump;
    logic [16:0]  s5_q;
    logic [31:0]  s5_mag_reg, s5_mag_next;
    logic         s5_neg_reg, s5_zero_reg;

    logic [64:0]  s6_prod_reg, s6_prod_next;
    logic         s6_neg_reg, s6_zero_reg;

    logic [64:0]        s7_rnd_sum;
    logic [33:0]        s7_rnd;
    logic signed [34:0] s7_sgn_reg, s7_sgn_next;
    logic               s7_zero_reg;

    logic signed [35:0] s8_sum;
    logic signed [31:0] s8_value_reg, s8_value_next;

    // Configuration registers and the ordered range derived from them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg    <= '0;
            range_high_reg   <= RANGE_HIGH_RESET;
            message_kind_reg <= 1'b0;
            curve_kind_reg   <= CURVE_LINEAR;
            accel_enable_reg <= 1'b0;
            range_bottom_reg <= '0;
            range_span_reg   <= 33'(RANGE_HIGH_RESET);
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_RANGE_LOW:    range_low_reg    <= cfg_data;
                    REG_RANGE_HIGH:   range_high_reg   <= cfg_data;
                    REG_MESSAGE_KIND: message_kind_reg <= cfg_data[0];
                    REG_CURVE_KIND:   curve_kind_reg   <= cfg_data[1:0];
                    REG_ACCEL_ENABLE: accel_enable_reg <= cfg_data[0];
                    default:          ;
                endcase
            end
            range_bottom_reg <= range_bottom_next;
            range_span_reg   <= range_span_next;
        end
    end

    always_comb
    begin
        if (range_low_reg < range_high_reg)
        begin
            range_bottom_next = range_low_reg;
            range_top_next    = range_high_reg;
        end
        else
        begin
            range_bottom_next = range_high_reg;
            range_top_next    = range_low_reg;
        end
        range_span_next = 33'(33'(range_top_next) - 33'(range_bottom_next));
    end

    // A stage loads when it is empty or its word moves on.
    always_comb
    begin
        load[8] = !valid_reg[8] || mapped_ready;
        for (int k = 7; k >= 1; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign value_ready  = load[1];
    assign mapped_valid = valid_reg[8];
    assign mapped_value = s8_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[1])
            begin
                valid_reg[1] <= value_valid;
            end
            for (int k = 2; k <= 8; k++)
            begin
                if (load[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 1: normalize the raw value.
    assign bend_d   = signed'({1'b0, midi_value}) - signed'({1'b0, BEND_CENTER});
    assign bend_mag = bend_d[14] ? 14'(-bend_d) : bend_d[13:0];
    assign accel_on = message_kind_reg && accel_enable_reg;

    always_comb
    begin
        s1_dist_next = (bend_mag > ACC_DEAD) ? 13'(bend_mag - ACC_DEAD) : '0;
        if (message_kind_reg)
        begin
            s1_x_next = XW'(bend_d) <<< BEND_SHIFT;
        end
        else if (midi_value > 14'(CTRL_MAX))
        begin
            s1_x_next = ONE_S;
        end
        else
        begin
            s1_x_next = signed'(XW'(CTRL_TAB[midi_value[6:0]]));
        end
        if (accel_on)
        begin
            s1_op_next = OP_ACCEL;
        end
        else
        begin
            unique case (curve_kind_reg)
                CURVE_LINEAR: s1_op_next = OP_LINEAR;
                CURVE_LOG:    s1_op_next = OP_LOG;
                CURVE_SQUARE: s1_op_next = OP_SQUARE;
                default:      s1_op_next = OP_ZERO;
            endcase
        end
    end

    // Stage 2: shared squarer, range flags and table reads.
    assign s2_ax    = s1_x_reg[XW-1] ? (FRAC_BITS + 1)'(-s1_x_reg)
                                     : s1_x_reg[FRAC_BITS:0];
    assign s2_mul_a = (s1_op_reg == OP_ACCEL) ? (FRAC_BITS + 1)'(s1_dist_reg) : s2_ax;
    assign s2_sq_next  = 34'(s2_mul_a) * 34'(s2_mul_a);
    assign s2_neg_next = (s1_op_reg == OP_ACCEL) ? s1_neg_reg : s1_x_reg[XW-1];
    assign s2_idx      = s1_x_reg[FRAC_BITS-1 -: LOG_IDX_W];
    assign s2_op_next  = (s1_op_reg == OP_SQUARE && s2_ax < SQ_ZERO_LIM) ? OP_ZERO
                                                                         : s1_op_reg;

    // Stage 3: reciprocal estimate, interpolation product and curve magnitudes.
    assign s3_mhi        = {s2_sq_reg[ACC_SQ_W-1:0], 6'b0} + ACC_HI_BIAS;
    assign s3_qprod      = 61'(s3_mhi) * 61'(ACC_RECIP);
    assign s3_q_est_next = s3_qprod[60:44];
    assign s3_m_next     = {s2_sq_reg[ACC_SQ_W-1:0], 10'b0} + ACC_BIAS;
    assign s3_diff       = s2_hi_reg - s2_lo_reg;
    assign s3_t_next     = 40'(s3_diff) * 40'(s2_f_reg);
    assign s3_sq_sum     = 33'(s2_sq_reg[31:0]) + 33'(1 << (FRAC_BITS - 1));

    always_comb
    begin
        if (s2_ge_one_reg)
        begin
            s3_mag_sq = MAG_ONE;
        end
        else if (s2_le_neg_reg)
        begin
            s3_mag_sq = '0;
        end
        else
        begin
            s3_mag_sq = {s3_sq_sum[32:FRAC_BITS], 15'b0};
        end
        unique case (s2_op_reg)
            OP_LINEAR: s3_mag_next = {s2_ax_reg, 15'b0};
            OP_SQUARE: s3_mag_next = s3_mag_sq;
            default:   s3_mag_next = '0;
        endcase
    end

    // Stage 4: quotient check product and interpolated log value.
    assign s4_qd_next = 37'(s3_q_est_reg) * 37'(ACC_DIV);
    assign s4_y_log   = 33'(s3_lo_reg)
                      + 33'((s3_t_reg + 40'(1 << (LOG_FRAC_W - 1))) >> LOG_FRAC_W);

    always_comb
    begin
        s4_mag_next = s3_mag_reg;
        if (s3_op_reg == OP_LOG)
        begin
            if (s3_nonpos_reg)
            begin
                s4_mag_next = '0;
            end
            else if (s3_ge_one_reg)
            begin
                s4_mag_next = MAG_ONE;
            end
            else
            begin
                s4_mag_next = s4_y_log[31:0];
            end
        end
    end

    // Stage 5: correct the quotient estimate by at most one.
    assign s5_bump     = {1'b0, s4_m_reg} >= (s4_qd_reg + 37'(ACC_DIV));
    assign s5_q        = s4_q_est_reg + 17'(s5_bump);
    assign s5_mag_next = (s4_op_reg == OP_ACCEL) ? {s5_q, 15'b0} : s4_mag_reg;

    // Stage 6: scale by the range span.
    assign s6_prod_next = 65'(s5_mag_reg) * 65'(range_span_reg);

    // Stage 7: round and apply the sign.
    assign s7_rnd_sum  = s6_prod_reg + 65'(1 << 30);
    assign s7_rnd      = s7_rnd_sum[64:31];
    assign s7_sgn_next = s6_neg_reg ? -signed'(35'(s7_rnd)) : signed'(35'(s7_rnd));

    // Stage 8: offset by the bottom bound and saturate.
    assign s8_sum = 36'(range_bottom_reg) + 36'(s7_sgn_reg);

    always_comb
    begin
        if (s7_zero_reg)
        begin
            s8_value_next = '0;
        end
        else if (s8_sum > SAT_MAX)
        begin
            s8_value_next = SAT_MAX[31:0];
        end
        else if (s8_sum < SAT_MIN)
        begin
            s8_value_next = SAT_MIN[31:0];
        end
        else
        begin
            s8_value_next = s8_sum[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            s1_op_reg   <= s1_op_next;
            s1_neg_reg  <= bend_d[14];
            s1_dist_reg <= s1_dist_next;
            s1_x_reg    <= s1_x_next;
        end
        if (load[2])
        begin
            s2_op_reg     <= s2_op_next;
            s2_neg_reg    <= s2_neg_next;
            s2_sq_reg     <= s2_sq_next;
            s2_ax_reg     <= s2_ax;
            s2_lo_reg     <= LOG_LO[s2_idx];
            s2_hi_reg     <= LOG_HI[s2_idx];
            s2_f_reg      <= s1_x_reg[LOG_FRAC_W-1:0];
            s2_ge_one_reg <= s1_x_reg >= ONE_S;
            s2_le_neg_reg <= s1_x_reg <= NEG_ONE_S;
            s2_nonpos_reg <= s1_x_reg <= 0;
        end
        if (load[3])
        begin
            s3_op_reg     <= s2_op_reg;
            s3_neg_reg    <= s2_neg_reg;
            s3_q_est_reg  <= s3_q_est_next;
            s3_m_reg      <= s3_m_next;
            s3_t_reg      <= s3_t_next;
            s3_lo_reg     <= s2_lo_reg;
            s3_mag_reg    <= s3_mag_next;
            s3_nonpos_reg <= s2_nonpos_reg;
            s3_ge_one_reg <= s2_ge_one_reg;
        end
        if (load[4])
        begin
            s4_op_reg    <= s3_op_reg;
            s4_neg_reg   <= s3_neg_reg;
            s4_q_est_reg <= s3_q_est_reg;
            s4_m_reg     <= s3_m_reg;
            s4_qd_reg    <= s4_qd_next;
            s4_mag_reg   <= s4_mag_next;
        end
        if (load[5])
        begin
            s5_mag_reg  <= s5_mag_next;
            s5_neg_reg  <= s4_neg_reg;
            s5_zero_reg <= s4_op_reg == OP_ZERO;
        end
        if (load[6])
        begin
            s6_prod_reg <= s6_prod_next;
            s6_neg_reg  <= s5_neg_reg;
            s6_zero_reg <= s5_zero_reg;
        end
        if (load[7])
        begin
            s7_sgn_reg  <= s7_sgn_next;
            s7_zero_reg <= s6_zero_reg;
        end
        if (load[8])
        begin
            s8_value_reg <= s8_value_next;
        end
    end

`ifndef SYNTHESIS
    // The reciprocal estimate is never above the true quotient and at most one below it.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[4] && s4_op_reg == OP_ACCEL |->
            ({1'b0, s4_m_reg} >= s4_qd_reg) &&
            ({1'b0, s4_m_reg} < s4_qd_reg + 37'(ACC_DIV) + 37'(ACC_DIV)))
        else $error("acceleration quotient estimate out of bounds");

    // Every curve yields a magnitude within the unit range before scaling.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[5] |-> s5_mag_reg <= MAG_ONE)
        else $error("curve magnitude exceeds one");

    // The derived bottom and span reproduce the larger bound of the previous cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (34'(range_bottom_reg) + 34'(range_span_reg) ==
            34'(($past(range_low_reg) < $past(range_high_reg)) ?
                $past(range_high_reg) : $past(range_low_reg))))
        else $error("ordered range out of step with the bounds");
`endif

endmodule
